### rtl/lkvc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Request and response codes and the fixed field widths of the cache block.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;
   localparam int CAP_BITS    = 4;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd5;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUT    = 2'd0,
      CMD_GET    = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_GET_HIT   = 3'd2,
      ST_GET_MISS  = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_RM_ABSENT = 3'd5
   } status_type;

endpackage
`default_nettype wire

### rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative store with least-recently-used replacement.
//
// Requests (req_cmd, req_lookup_key, req_put_value) arrive on a valid/stall
// channel; a word is taken at an edge with req_valid high and req_stall low.
// Commands are put, get and remove; the fourth code does nothing and answers
// as a get miss. Every request gives exactly one response word on the rsp_
// channel (status, read value, eviction flag and victim key).
// A taken request is held in the input register and compared against all
// keys in parallel; its response is loaded into the response register with
// the updated entry state. One request is handled per cycle while the
// receiver does not stall; the limit is the single compare-and-update pass
// over the entry registers. When the receiver stalls, the response register
// holds and the input register fills; req_stall then rises until the
// response is taken. csr_wr_en writes the capacity in use (reset value 5);
// the user must use it only while the block is idle; the block does not
// enforce this. Synchronous reset empties the cache at once.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES    = 8,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [lkvc_pkg::CMD_BITS-1:0]     req_cmd,
   input  wire  [KEY_BITS-1:0]               req_lookup_key,
   input  wire  [VALUE_BITS-1:0]             req_put_value,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [lkvc_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [VALUE_BITS-1:0]             rsp_read_value,
   output logic                              rsp_evicted,
   output logic [KEY_BITS-1:0]               rsp_evicted_key,
   input  wire                               csr_wr_en,
   input  wire  [lkvc_pkg::CAP_BITS-1:0]     csr_wr_data
);

   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WIDE_BITS = (OCC_BITS > lkvc_pkg::CAP_BITS) ? OCC_BITS
                                                               : lkvc_pkg::CAP_BITS;
   localparam logic [WIDE_BITS-1:0] ENTRIES_W = WIDE_BITS'(ENTRIES);

   // Input register
   logic                           in_valid_ff, in_valid_in;
   lkvc_pkg::cmd_type              in_cmd_ff;
   logic [KEY_BITS-1:0]            in_key_ff;
   logic [VALUE_BITS-1:0]          in_value_ff;

   // Response register
   logic                           out_valid_ff, out_valid_in;
   lkvc_pkg::status_type           out_status_ff, out_status_in;
   logic [VALUE_BITS-1:0]          out_value_ff, out_value_in;
   logic                           out_evicted_ff, out_evicted_in;
   logic [KEY_BITS-1:0]            out_evkey_ff, out_evkey_in;

   // Entry state
   logic [KEY_BITS-1:0]            key_ff   [ENTRIES];
   logic [VALUE_BITS-1:0]          value_ff [ENTRIES];
   logic [RANK_BITS-1:0]           rank_ff  [ENTRIES];
   logic [RANK_BITS-1:0]           rank_in  [ENTRIES];
   logic [ENTRIES-1:0]             valid_ff, valid_in;
   logic [OCC_BITS-1:0]            occ_ff, occ_in;
   logic [lkvc_pkg::CAP_BITS-1:0]  cap_ff, cap_in;

   logic                           accept, advance;
   logic [ENTRIES-1:0]             hit, oldest, valid_kept, free, slot, write_en;
   logic                           hit_any, evict, insert, is_put;
   logic [RANK_BITS-1:0]           hit_rank, occ_last;
   logic [VALUE_BITS-1:0]          hit_value;
   logic [KEY_BITS-1:0]            oldest_key;
   logic [WIDE_BITS-1:0]           cap_wide, cap_eff, occ_wide;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_read_value  = out_value_ff;
   assign rsp_evicted     = out_evicted_ff;
   assign rsp_evicted_key = out_evkey_ff;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // Parallel compare, and the victim found as the entry whose rank is
   // occupancy minus one, since valid ranks are always 0 .. occupancy-1.
   always_comb begin
      occ_last   = RANK_BITS'(occ_ff - OCC_BITS'(1));
      hit_rank   = '0;
      hit_value  = '0;
      oldest_key = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i]    = valid_ff[i] && (key_ff[i] == in_key_ff);
         oldest[i] = valid_ff[i] && (rank_ff[i] == occ_last);
         if (hit[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
         if (oldest[i]) begin
            oldest_key = oldest_key | key_ff[i];
         end
      end
      hit_any = |hit;
   end

   always_comb begin
      cap_wide = WIDE_BITS'(cap_ff);
      occ_wide = WIDE_BITS'(occ_ff);
      if (cap_ff == '0) begin
         cap_eff = WIDE_BITS'(1);
      end else if (cap_wide > ENTRIES_W) begin
         cap_eff = ENTRIES_W;
      end else begin
         cap_eff = cap_wide;
      end
      is_put     = (in_cmd_ff == lkvc_pkg::CMD_PUT);
      evict      = is_put && !hit_any && (occ_wide >= cap_eff);
      valid_kept = evict ? (valid_ff & ~oldest) : valid_ff;
      free       = ~valid_kept;
      // Lowest free slot: isolate the least significant set bit.
      slot       = free & (~free + ENTRIES'(1));
      insert     = is_put && !hit_any && (|free);
   end

   always_comb begin
      valid_in       = valid_ff;
      occ_in         = occ_ff;
      out_status_in  = lkvc_pkg::ST_GET_MISS;
      out_value_in   = '0;
      out_evicted_in = 1'b0;
      out_evkey_in   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      unique case (in_cmd_ff)
         lkvc_pkg::CMD_PUT: begin
            if (hit_any) begin
               out_status_in = lkvc_pkg::ST_UPDATED;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                     rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                  end
               end
            end else begin
               out_status_in  = lkvc_pkg::ST_INSERTED;
               out_evicted_in = evict;
               out_evkey_in   = evict ? oldest_key : '0;
               // The victim is the oldest, so no surviving rank moves on eviction.
               for (int i = 0; i < ENTRIES; i++) begin
                  if (insert && slot[i]) begin
                     valid_in[i] = 1'b1;
                     rank_in[i]  = '0;
                  end else if (valid_kept[i]) begin
                     rank_in[i] = insert ? rank_ff[i] + RANK_BITS'(1) : rank_ff[i];
                  end else begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end
               end
               occ_in = occ_ff - OCC_BITS'(evict) + OCC_BITS'(insert);
            end
         end
         lkvc_pkg::CMD_GET: begin
            if (hit_any) begin
               out_status_in = lkvc_pkg::ST_GET_HIT;
               out_value_in  = hit_value;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit[i]) begin
                     rank_in[i] = '0;
                  end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                     rank_in[i] = rank_ff[i] + RANK_BITS'(1);
                  end
               end
            end
         end
         lkvc_pkg::CMD_REMOVE: begin
            if (hit_any) begin
               out_status_in = lkvc_pkg::ST_REMOVED;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (hit[i]) begin
                     valid_in[i] = 1'b0;
                     rank_in[i]  = '0;
                  end else if (valid_ff[i] && (rank_ff[i] > hit_rank)) begin
                     rank_in[i] = rank_ff[i] - RANK_BITS'(1);
                  end
               end
               occ_in = occ_ff - OCC_BITS'(1);
            end else begin
               out_status_in = lkvc_pkg::ST_RM_ABSENT;
            end
         end
         lkvc_pkg::CMD_NOP: begin
            out_status_in = lkvc_pkg::ST_GET_MISS;
         end
         default: begin
            out_status_in = lkvc_pkg::ST_GET_MISS;
         end
      endcase
      for (int i = 0; i < ENTRIES; i++) begin
         write_en[i] = advance && ((is_put && hit[i]) || (insert && slot[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= lkvc_pkg::CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         cap_ff       <= cap_in;
         if (advance) begin
            valid_ff <= valid_in;
            occ_ff   <= occ_in;
            for (int i = 0; i < ENTRIES; i++) begin
               rank_ff[i] <= rank_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff   <= lkvc_pkg::cmd_type'(req_cmd);
         in_key_ff   <= req_lookup_key;
         in_value_ff <= req_put_value;
      end
      if (advance) begin
         out_status_ff  <= out_status_in;
         out_value_ff   <= out_value_in;
         out_evicted_ff <= out_evicted_in;
         out_evkey_ff   <= out_evkey_in;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (write_en[i]) begin
            key_ff[i]   <= in_key_ff;
            value_ff[i] <= in_value_ff;
         end
      end
   end

endmodule
`default_nettype wire
